// ===== design/fcc_nbr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_nbr_pkg
// Shared types, constants and the nearest-neighbour offset table for the
// FCC neighbour density update block.
// ----------------------------------------------------------------------------
package fcc_nbr_pkg;

  localparam int COORD_W   = 5;
  localparam int SUB_W     = 2;
  localparam int DENS_W    = 4;
  localparam int CFG_W     = 6;
  localparam int IDX_W     = 4;

  localparam logic [DENS_W-1:0] DENS_MAX      = 4'd15;
  localparam logic [CFG_W-1:0]  LATTICE_RESET = 6'd32;
  localparam logic [IDX_W-1:0]  LAST_IDX      = 4'd11;

  // command codes
  localparam logic CMD_PLACE  = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // cell offset codes
  localparam logic [1:0] OFS_NEG  = 2'd0;
  localparam logic [1:0] OFS_ZERO = 2'd1;
  localparam logic [1:0] OFS_POS  = 2'd2;

  typedef struct packed {
    logic [1:0]       dx;
    logic [1:0]       dy;
    logic [1:0]       dz;
    logic [SUB_W-1:0] nb;
  } nbr_ofs_t;

  typedef struct packed {
    logic             clear;
    logic             load;
    logic             issue;
    logic [IDX_W-1:0] idx;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_done;
  } dp_status_t;

  // k-th nearest neighbour of a site in walk order (x, y, z offset, then sublattice)
  function automatic nbr_ofs_t nbr_ofs(input logic [SUB_W-1:0] sub,
                                       input logic [IDX_W-1:0] idx);
    nbr_ofs_t r;
    case ({sub, idx})
      {2'd0, 4'd0}:  r = '{OFS_NEG,  OFS_NEG,  OFS_ZERO, 2'd1};
      {2'd0, 4'd1}:  r = '{OFS_NEG,  OFS_ZERO, OFS_NEG,  2'd2};
      {2'd0, 4'd2}:  r = '{OFS_NEG,  OFS_ZERO, OFS_ZERO, 2'd1};
      {2'd0, 4'd3}:  r = '{OFS_NEG,  OFS_ZERO, OFS_ZERO, 2'd2};
      {2'd0, 4'd4}:  r = '{OFS_ZERO, OFS_NEG,  OFS_NEG,  2'd3};
      {2'd0, 4'd5}:  r = '{OFS_ZERO, OFS_NEG,  OFS_ZERO, 2'd1};
      {2'd0, 4'd6}:  r = '{OFS_ZERO, OFS_NEG,  OFS_ZERO, 2'd3};
      {2'd0, 4'd7}:  r = '{OFS_ZERO, OFS_ZERO, OFS_NEG,  2'd2};
      {2'd0, 4'd8}:  r = '{OFS_ZERO, OFS_ZERO, OFS_NEG,  2'd3};
      {2'd0, 4'd9}:  r = '{OFS_ZERO, OFS_ZERO, OFS_ZERO, 2'd1};
      {2'd0, 4'd10}: r = '{OFS_ZERO, OFS_ZERO, OFS_ZERO, 2'd2};
      {2'd0, 4'd11}: r = '{OFS_ZERO, OFS_ZERO, OFS_ZERO, 2'd3};
      {2'd1, 4'd0}:  r = '{OFS_ZERO, OFS_ZERO, OFS_NEG,  2'd2};
      {2'd1, 4'd1}:  r = '{OFS_ZERO, OFS_ZERO, OFS_NEG,  2'd3};
      {2'd1, 4'd2}:  r = '{OFS_ZERO, OFS_ZERO, OFS_ZERO, 2'd0};
      {2'd1, 4'd3}:  r = '{OFS_ZERO, OFS_ZERO, OFS_ZERO, 2'd2};
      {2'd1, 4'd4}:  r = '{OFS_ZERO, OFS_ZERO, OFS_ZERO, 2'd3};
      {2'd1, 4'd5}:  r = '{OFS_ZERO, OFS_POS,  OFS_NEG,  2'd2};
      {2'd1, 4'd6}:  r = '{OFS_ZERO, OFS_POS,  OFS_ZERO, 2'd0};
      {2'd1, 4'd7}:  r = '{OFS_ZERO, OFS_POS,  OFS_ZERO, 2'd2};
      {2'd1, 4'd8}:  r = '{OFS_POS,  OFS_ZERO, OFS_NEG,  2'd3};
      {2'd1, 4'd9}:  r = '{OFS_POS,  OFS_ZERO, OFS_ZERO, 2'd0};
      {2'd1, 4'd10}: r = '{OFS_POS,  OFS_ZERO, OFS_ZERO, 2'd3};
      {2'd1, 4'd11}: r = '{OFS_POS,  OFS_POS,  OFS_ZERO, 2'd0};
      {2'd2, 4'd0}:  r = '{OFS_ZERO, OFS_NEG,  OFS_ZERO, 2'd1};
      {2'd2, 4'd1}:  r = '{OFS_ZERO, OFS_NEG,  OFS_ZERO, 2'd3};
      {2'd2, 4'd2}:  r = '{OFS_ZERO, OFS_NEG,  OFS_POS,  2'd1};
      {2'd2, 4'd3}:  r = '{OFS_ZERO, OFS_ZERO, OFS_ZERO, 2'd0};
      {2'd2, 4'd4}:  r = '{OFS_ZERO, OFS_ZERO, OFS_ZERO, 2'd1};
      {2'd2, 4'd5}:  r = '{OFS_ZERO, OFS_ZERO, OFS_ZERO, 2'd3};
      {2'd2, 4'd6}:  r = '{OFS_ZERO, OFS_ZERO, OFS_POS,  2'd0};
      {2'd2, 4'd7}:  r = '{OFS_ZERO, OFS_ZERO, OFS_POS,  2'd1};
      {2'd2, 4'd8}:  r = '{OFS_POS,  OFS_NEG,  OFS_ZERO, 2'd3};
      {2'd2, 4'd9}:  r = '{OFS_POS,  OFS_ZERO, OFS_ZERO, 2'd0};
      {2'd2, 4'd10}: r = '{OFS_POS,  OFS_ZERO, OFS_ZERO, 2'd3};
      {2'd2, 4'd11}: r = '{OFS_POS,  OFS_ZERO, OFS_POS,  2'd0};
      {2'd3, 4'd0}:  r = '{OFS_NEG,  OFS_ZERO, OFS_ZERO, 2'd1};
      {2'd3, 4'd1}:  r = '{OFS_NEG,  OFS_ZERO, OFS_ZERO, 2'd2};
      {2'd3, 4'd2}:  r = '{OFS_NEG,  OFS_ZERO, OFS_POS,  2'd1};
      {2'd3, 4'd3}:  r = '{OFS_NEG,  OFS_POS,  OFS_ZERO, 2'd2};
      {2'd3, 4'd4}:  r = '{OFS_ZERO, OFS_ZERO, OFS_ZERO, 2'd0};
      {2'd3, 4'd5}:  r = '{OFS_ZERO, OFS_ZERO, OFS_ZERO, 2'd1};
      {2'd3, 4'd6}:  r = '{OFS_ZERO, OFS_ZERO, OFS_ZERO, 2'd2};
      {2'd3, 4'd7}:  r = '{OFS_ZERO, OFS_ZERO, OFS_POS,  2'd0};
      {2'd3, 4'd8}:  r = '{OFS_ZERO, OFS_ZERO, OFS_POS,  2'd1};
      {2'd3, 4'd9}:  r = '{OFS_ZERO, OFS_POS,  OFS_ZERO, 2'd0};
      {2'd3, 4'd10}: r = '{OFS_ZERO, OFS_POS,  OFS_ZERO, 2'd2};
      {2'd3, 4'd11}: r = '{OFS_ZERO, OFS_POS,  OFS_POS,  2'd0};
      default:       r = '{OFS_ZERO, OFS_ZERO, OFS_ZERO, 2'd0};
    endcase
    return r;
  endfunction

endpackage

// ===== design/fcc_nbr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_nbr_ctrl
// Sequencer: runs the map clearing pass after reset, accepts commands and
// steps the neighbour index through the twelve read-modify-write slots.
// ----------------------------------------------------------------------------
module fcc_nbr_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  output fcc_nbr_pkg::ctrl_cmd_t  ctrl,
  input  fcc_nbr_pkg::dp_status_t status
);
  import fcc_nbr_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_RUN
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             accept;

  // a new command may enter during the last issue slot of the previous one
  assign busy   = !((state_r == S_IDLE) || ((state_r == S_RUN) && (idx_r == LAST_IDX)));
  assign accept = start && !busy;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    case (state_r)
      S_CLEAR: begin
        if (status.clear_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_RUN;
          idx_nxt   = '0;
        end
      end
      S_RUN: begin
        if (idx_r == LAST_IDX) begin
          idx_nxt   = '0;
          state_nxt = accept ? S_RUN : S_IDLE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      default: begin
        state_nxt = S_CLEAR;
        idx_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign ctrl.clear = (state_r == S_CLEAR);
  assign ctrl.load  = accept;
  assign ctrl.issue = (state_r == S_RUN);
  assign ctrl.idx   = idx_r;

endmodule

// ===== design/fcc_nbr_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_nbr_datapath
// Lattice size register, command latch, neighbour address generation with
// periodic wrap, density map memory and the saturating update pipeline.
// ----------------------------------------------------------------------------
module fcc_nbr_datapath #(
  parameter int MAX_CELLS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fcc_nbr_pkg::ctrl_cmd_t              ctrl,
  output fcc_nbr_pkg::dp_status_t             status,
  input  logic                                cfg_we,
  input  logic [fcc_nbr_pkg::CFG_W-1:0]       cfg_data,
  input  logic                                in_cmd,
  input  logic [fcc_nbr_pkg::COORD_W-1:0]     in_cell_x,
  input  logic [fcc_nbr_pkg::COORD_W-1:0]     in_cell_y,
  input  logic [fcc_nbr_pkg::COORD_W-1:0]     in_cell_z,
  input  logic [fcc_nbr_pkg::SUB_W-1:0]       in_sublattice,
  output logic                                out_valid,
  output logic [fcc_nbr_pkg::COORD_W-1:0]     out_nbr_x,
  output logic [fcc_nbr_pkg::COORD_W-1:0]     out_nbr_y,
  output logic [fcc_nbr_pkg::COORD_W-1:0]     out_nbr_z,
  output logic [fcc_nbr_pkg::SUB_W-1:0]       out_nbr_sub,
  output logic [fcc_nbr_pkg::DENS_W-1:0]      out_new_density,
  output logic                                out_last
);
  import fcc_nbr_pkg::*;

  localparam int CW    = $clog2(MAX_CELLS);
  localparam int SW    = $clog2(MAX_CELLS + 1);
  localparam int AW    = 3 * CW + SUB_W;
  localparam int DEPTH = 2 ** AW;

  function automatic logic [CW-1:0] clamp_coord(input logic [COORD_W-1:0] c,
                                                input logic [SW-1:0]      size);
    if (32'(c) >= 32'(size)) begin
      clamp_coord = CW'(size - SW'(1));
    end else begin
      clamp_coord = CW'(c);
    end
  endfunction

  function automatic logic [CW-1:0] wrap_coord(input logic [CW-1:0] pos,
                                               input logic [1:0]    ofs,
                                               input logic [SW-1:0] size);
    logic [SW-1:0] up;
    up = SW'(pos) + SW'(1);
    case (ofs)
      OFS_NEG: wrap_coord = (pos == '0) ? CW'(size - SW'(1)) : pos - CW'(1);
      OFS_POS: wrap_coord = (up == size) ? '0 : CW'(up);
      default: wrap_coord = pos;
    endcase
  endfunction

  logic [CFG_W-1:0]  lattice_size_r;
  logic [SW-1:0]     eff_size;

  logic              cmd_r;
  logic [CW-1:0]     pos_x_r, pos_y_r, pos_z_r;
  logic [SUB_W-1:0]  sub_r;

  logic [AW-1:0]     clr_addr_r;

  nbr_ofs_t          ofs;
  logic [CW-1:0]     nx, ny, nz;
  logic [AW-1:0]     rd_addr;

  logic [DENS_W-1:0] density_mem [DEPTH];
  logic [DENS_W-1:0] mem_rd_r;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [DENS_W-1:0] mem_wd;

  logic              s2_valid_r;
  logic [AW-1:0]     s2_addr_r;
  logic              s2_dec_r;
  logic              s2_last_r;

  logic              wr_valid_r;
  logic [AW-1:0]     wr_addr_r;
  logic [DENS_W-1:0] wr_data_r;

  logic [DENS_W-1:0] old_dens, new_dens;

  logic              out_valid_r, out_last_r;
  logic [COORD_W-1:0] out_x_r, out_y_r, out_z_r;
  logic [SUB_W-1:0]  out_sub_r;
  logic [DENS_W-1:0] out_dens_r;

  // lattice size clamped into 1..MAX_CELLS
  always_comb begin
    if (lattice_size_r == '0) begin
      eff_size = SW'(1);
    end else if (32'(lattice_size_r) > 32'(MAX_CELLS)) begin
      eff_size = SW'(MAX_CELLS);
    end else begin
      eff_size = SW'(lattice_size_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lattice_size_r <= LATTICE_RESET;
    end else if (cfg_we) begin
      lattice_size_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r   <= in_cmd;
      pos_x_r <= clamp_coord(in_cell_x, eff_size);
      pos_y_r <= clamp_coord(in_cell_y, eff_size);
      pos_z_r <= clamp_coord(in_cell_z, eff_size);
      sub_r   <= in_sublattice;
    end
  end

  // clearing pass address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (ctrl.clear) begin
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  assign status.clear_done = &clr_addr_r;

  // neighbour address for the current slot
  always_comb begin
    ofs     = nbr_ofs(sub_r, ctrl.idx);
    nx      = wrap_coord(pos_x_r, ofs.dx, eff_size);
    ny      = wrap_coord(pos_y_r, ofs.dy, eff_size);
    nz      = wrap_coord(pos_z_r, ofs.dz, eff_size);
    rd_addr = {nx, ny, nz, ofs.nb};
  end

  // density map, read-first
  assign mem_we = ctrl.clear || s2_valid_r;
  assign mem_wa = ctrl.clear ? clr_addr_r : s2_addr_r;
  assign mem_wd = ctrl.clear ? '0 : new_dens;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      density_mem[mem_wa] <= mem_wd;
    end
    mem_rd_r <= density_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      wr_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= ctrl.issue;
      wr_valid_r <= s2_valid_r;
    end
    s2_addr_r <= rd_addr;
    s2_dec_r  <= (cmd_r == CMD_REMOVE);
    s2_last_r <= (ctrl.idx == LAST_IDX);
    wr_addr_r <= s2_addr_r;
    wr_data_r <= new_dens;
  end

  // forward the write of the previous slot when it hits the same entry
  always_comb begin
    if (wr_valid_r && (wr_addr_r == s2_addr_r)) begin
      old_dens = wr_data_r;
    end else begin
      old_dens = mem_rd_r;
    end
    if (s2_dec_r) begin
      new_dens = (old_dens == '0) ? '0 : old_dens - DENS_W'(1);
    end else begin
      new_dens = (old_dens == DENS_MAX) ? DENS_MAX : old_dens + DENS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      out_valid_r <= s2_valid_r;
      out_last_r  <= s2_valid_r && s2_last_r;
    end
    out_x_r    <= COORD_W'(s2_addr_r[AW-1 -: CW]);
    out_y_r    <= COORD_W'(s2_addr_r[AW-CW-1 -: CW]);
    out_z_r    <= COORD_W'(s2_addr_r[SUB_W+CW-1 -: CW]);
    out_sub_r  <= s2_addr_r[SUB_W-1:0];
    out_dens_r <= new_dens;
  end

  assign out_valid       = out_valid_r;
  assign out_last        = out_last_r;
  assign out_nbr_x       = out_x_r;
  assign out_nbr_y       = out_y_r;
  assign out_nbr_z       = out_z_r;
  assign out_nbr_sub     = out_sub_r;
  assign out_new_density = out_dens_r;

endmodule

// ===== design/fcc_neighbor_density_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_neighbor_density_update
// Place or remove an atom on a periodic FCC lattice and update the 4-bit
// saturating density count of its twelve nearest neighbours.
// ----------------------------------------------------------------------------
// Usage:
//   A command word (in_cmd, in_cell_x/y/z, in_sublattice) is taken at a
//   clock edge with start high and busy low. It produces twelve result words,
//   one per cycle, each on the out_ ports for one cycle with out_valid high;
//   out_last marks the twelfth. The receiver cannot stall the block.
//   The command is latched, each neighbour entry is read and updated in a
//   second stage, with the previous write forwarded, and the result word is
//   registered onto the out_ ports. Neighbours are updated one per cycle;
//   a new command is taken in the last issue slot of the previous one, so
//   commands can follow back to back.
//   cfg_we/cfg_data write the lattice size (reset 32); write it only while
//   no command is in flight.
//   Reset: after rst_n the map is cleared one entry per cycle, over all
//   2**(3*clog2(MAX_CELLS)+2) entries (131072 at MAX_CELLS = 32), with busy
//   high; configuration writes are taken during that pass.
// ----------------------------------------------------------------------------
module fcc_neighbor_density_update #(
  parameter int MAX_CELLS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_cmd,
  input  logic [fcc_nbr_pkg::COORD_W-1:0] in_cell_x,
  input  logic [fcc_nbr_pkg::COORD_W-1:0] in_cell_y,
  input  logic [fcc_nbr_pkg::COORD_W-1:0] in_cell_z,
  input  logic [fcc_nbr_pkg::SUB_W-1:0]   in_sublattice,
  input  logic                            cfg_we,
  input  logic [fcc_nbr_pkg::CFG_W-1:0]   cfg_data,
  output logic                            out_valid,
  output logic [fcc_nbr_pkg::COORD_W-1:0] out_nbr_x,
  output logic [fcc_nbr_pkg::COORD_W-1:0] out_nbr_y,
  output logic [fcc_nbr_pkg::COORD_W-1:0] out_nbr_z,
  output logic [fcc_nbr_pkg::SUB_W-1:0]   out_nbr_sub,
  output logic [fcc_nbr_pkg::DENS_W-1:0]  out_new_density,
  output logic                            out_last
);
  import fcc_nbr_pkg::*;

  ctrl_cmd_t  ctrl;
  dp_status_t status;

  fcc_nbr_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .ctrl   (ctrl),
    .status (status)
  );

  fcc_nbr_datapath #(
    .MAX_CELLS (MAX_CELLS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctrl            (ctrl),
    .status          (status),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .in_cmd          (in_cmd),
    .in_cell_x       (in_cell_x),
    .in_cell_y       (in_cell_y),
    .in_cell_z       (in_cell_z),
    .in_sublattice   (in_sublattice),
    .out_valid       (out_valid),
    .out_nbr_x       (out_nbr_x),
    .out_nbr_y       (out_nbr_y),
    .out_nbr_z       (out_nbr_z),
    .out_nbr_sub     (out_nbr_sub),
    .out_new_density (out_new_density),
    .out_last        (out_last)
  );

endmodule

// ===== design/fcc_nbr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_nbr_checker
// Port-level checks of command acceptance and result word bursts.
// ----------------------------------------------------------------------------
module fcc_nbr_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic out_last
);

  // an accepted command is followed by busy high, blocking the next one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy low right after an accepted command");

  // last marks only a valid word
  a_last_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> out_valid)
    else $error("out_last without out_valid");

  // the twelve words of a command come without gaps
  a_burst_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid || !$past(rst_n))
    else $error("gap inside a result burst");

  // the last word closes a burst of twelve
  a_burst_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> $past(out_valid, 11))
    else $error("result burst shorter than twelve words");

  // reset clears the result strobe
  a_reset_clears_valid: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

endmodule

bind fcc_neighbor_density_update fcc_nbr_checker u_fcc_nbr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_last  (out_last)
);

// ===== verif/tb_fcc_neighbor_density_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fcc_neighbor_density_update
// Self-checking bench for the FCC neighbor density update block. A queue of
// command, lattice size and drain entries feeds a falling-edge driver. A
// rising-edge monitor keeps a shadow density map, predicts the twelve
// neighbor words of every accepted command and checks each output word
// against them in order. Directed corner cases run first, then three
// randomized phases with different sender idle rates.
// ----------------------------------------------------------------------------
module tb_fcc_neighbor_density_update;
  import fcc_nbr_pkg::*;

  localparam int GRID_MAX   = 32;
  localparam int MAP_WORDS  = GRID_MAX * GRID_MAX * GRID_MAX * 4;
  localparam int NBR_COUNT  = 12;
  localparam int TIMEOUT_NS = 12_000_000;

  typedef enum {ITEM_CMD, ITEM_CFG, ITEM_DRAIN} item_kind_t;

  typedef struct {
    item_kind_t         kind;
    logic               cmd;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [SUB_W-1:0]   sub;
    logic [CFG_W-1:0]   size;
    int                 idle_pct;
  } stim_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [SUB_W-1:0]   sub;
    logic [DENS_W-1:0]  dens;
    logic               last;
  } nbr_word_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               in_cmd = CMD_PLACE;
  logic [COORD_W-1:0] in_cell_x = '0;
  logic [COORD_W-1:0] in_cell_y = '0;
  logic [COORD_W-1:0] in_cell_z = '0;
  logic [SUB_W-1:0]   in_sublattice = '0;
  logic               cfg_we = 1'b0;
  logic [CFG_W-1:0]   cfg_data = LATTICE_RESET;
  logic               out_valid;
  logic [COORD_W-1:0] out_nbr_x;
  logic [COORD_W-1:0] out_nbr_y;
  logic [COORD_W-1:0] out_nbr_z;
  logic [SUB_W-1:0]   out_nbr_sub;
  logic [DENS_W-1:0]  out_new_density;
  logic               out_last;

  stim_item_t       pending_items[$];
  nbr_word_t        nbr_expect_q[$];
  bit [DENS_W-1:0]  site_density [0:MAP_WORDS-1];
  logic [CFG_W-1:0] lattice_cfg = LATTICE_RESET;
  logic             took = 1'b0;
  int               cur_idle = 0;
  int               errors = 0;
  int               cmds_taken = 0;
  int               words_checked = 0;
  int               cfg_writes = 0;
  int               sat_hits = 0;

  fcc_neighbor_density_update #(
    .MAX_CELLS(GRID_MAX)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_cell_x      (in_cell_x),
    .in_cell_y      (in_cell_y),
    .in_cell_z      (in_cell_z),
    .in_sublattice  (in_sublattice),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_nbr_x      (out_nbr_x),
    .out_nbr_y      (out_nbr_y),
    .out_nbr_z      (out_nbr_z),
    .out_nbr_sub    (out_nbr_sub),
    .out_new_density(out_new_density),
    .out_last       (out_last)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb_fcc_neighbor_density_update NOT OK");
    $finish;
  end

  // doubled-unit offset of a basis site along one axis
  function automatic int face_ofs(input int nb, input int ax);
    return ((nb == 1 && ax != 2) || (nb == 2 && ax != 1) || (nb == 3 && ax != 0)) ? 1 : 0;
  endfunction

  function automatic int clamp_size(input logic [CFG_W-1:0] raw);
    int s;
    s = int'(raw);
    if (s < 1) s = 1;
    if (s > GRID_MAX) s = GRID_MAX;
    return s;
  endfunction

  task automatic predict_density_update(input logic cmd, input logic [COORD_W-1:0] cx,
                                        input logic [COORD_W-1:0] cy,
                                        input logic [COORD_W-1:0] cz,
                                        input logic [SUB_W-1:0] sub);
    int size;
    int pos [3];
    int ofs [3];
    int nbr_pos [3];
    int comp;
    int dist2;
    int n;
    int addr;
    logic [DENS_W-1:0] cnt;
    nbr_word_t w;
    size = clamp_size(lattice_cfg);
    pos[0] = int'(cx);
    pos[1] = int'(cy);
    pos[2] = int'(cz);
    for (int ax = 0; ax < 3; ax++) begin
      if (pos[ax] >= size) pos[ax] = size - 1;
    end
    n = 0;
    for (int dx = -1; dx <= 1; dx++) begin
      for (int dy = -1; dy <= 1; dy++) begin
        for (int dz = -1; dz <= 1; dz++) begin
          for (int nb = 0; nb < 4; nb++) begin
            ofs[0] = dx;
            ofs[1] = dy;
            ofs[2] = dz;
            dist2 = 0;
            for (int ax = 0; ax < 3; ax++) begin
              comp = 2 * ofs[ax] + face_ofs(nb, ax) - face_ofs(int'(sub), ax);
              dist2 += comp * comp;
            end
            if (dist2 == 2 && n < NBR_COUNT) begin
              for (int ax = 0; ax < 3; ax++) begin
                nbr_pos[ax] = pos[ax] + ofs[ax];
                if (nbr_pos[ax] >= size) nbr_pos[ax] = 0;
                else if (nbr_pos[ax] < 0) nbr_pos[ax] = size - 1;
              end
              addr = ((nbr_pos[0] * GRID_MAX + nbr_pos[1]) * GRID_MAX + nbr_pos[2]) * 4 + nb;
              cnt = site_density[addr];
              if (cmd == CMD_PLACE) begin
                if (cnt != DENS_MAX) cnt = cnt + 1'b1;
                else sat_hits++;
              end else begin
                if (cnt != '0) cnt = cnt - 1'b1;
                else sat_hits++;
              end
              site_density[addr] = cnt;
              w.x    = COORD_W'(nbr_pos[0]);
              w.y    = COORD_W'(nbr_pos[1]);
              w.z    = COORD_W'(nbr_pos[2]);
              w.sub  = SUB_W'(nb);
              w.dens = cnt;
              w.last = (n == int'(LAST_IDX));
              nbr_expect_q.push_back(w);
              n++;
            end
          end
        end
      end
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
  endtask

  task automatic push_cmd(input logic cmd, input logic [COORD_W-1:0] x,
                          input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z,
                          input logic [SUB_W-1:0] sub);
    stim_item_t it;
    it.kind = ITEM_CMD;
    it.cmd = cmd;
    it.x = x;
    it.y = y;
    it.z = z;
    it.sub = sub;
    it.size = '0;
    it.idle_pct = cur_idle;
    pending_items.push_back(it);
  endtask

  task automatic push_cfg(input logic [CFG_W-1:0] size);
    stim_item_t it;
    it = '{ITEM_CFG, CMD_PLACE, '0, '0, '0, '0, size, 0};
    pending_items.push_back(it);
  endtask

  task automatic push_drain();
    stim_item_t it;
    it = '{ITEM_DRAIN, CMD_PLACE, '0, '0, '0, '0, '0, 0};
    pending_items.push_back(it);
  endtask

  // driver
  always @(negedge clk) begin : drive_proc
    stim_item_t it;
    logic go;
    logic we;
    if (rst_n && !(start && !took)) begin
      go = 1'b0;
      we = 1'b0;
      if (pending_items.size() != 0) begin
        it = pending_items[0];
        case (it.kind)
          ITEM_CMD: begin
            if ($urandom_range(99) >= it.idle_pct) begin
              void'(pending_items.pop_front());
              in_cmd        <= it.cmd;
              in_cell_x     <= it.x;
              in_cell_y     <= it.y;
              in_cell_z     <= it.z;
              in_sublattice <= it.sub;
              go = 1'b1;
            end
          end
          ITEM_CFG: begin
            if (nbr_expect_q.size() == 0 && !busy) begin
              void'(pending_items.pop_front());
              cfg_data <= it.size;
              we = 1'b1;
            end
          end
          default: begin
            if (nbr_expect_q.size() == 0) void'(pending_items.pop_front());
          end
        endcase
      end
      start  <= go;
      cfg_we <= we;
    end
  end

  // monitor and predictor
  always @(posedge clk) begin : monitor_proc
    nbr_word_t w;
    took <= start && !busy;
    if (rst_n) begin
      if (out_valid) begin
        if (nbr_expect_q.size() == 0) begin
          report_mismatch("word with nothing expected, nbr_x", int'(out_nbr_x), -1);
        end else begin
          w = nbr_expect_q.pop_front();
          words_checked++;
          if (out_nbr_x != w.x) report_mismatch("nbr_x", int'(out_nbr_x), int'(w.x));
          if (out_nbr_y != w.y) report_mismatch("nbr_y", int'(out_nbr_y), int'(w.y));
          if (out_nbr_z != w.z) report_mismatch("nbr_z", int'(out_nbr_z), int'(w.z));
          if (out_nbr_sub != w.sub) report_mismatch("nbr_sub", int'(out_nbr_sub), int'(w.sub));
          if (out_new_density != w.dens) begin
            report_mismatch("new_density", int'(out_new_density), int'(w.dens));
          end
          if (out_last != w.last) report_mismatch("last", int'(out_last), int'(w.last));
        end
      end
      if (cfg_we) begin
        lattice_cfg = cfg_data;
        cfg_writes++;
      end
      if (start && !busy) begin
        cmds_taken++;
        predict_density_update(in_cmd, in_cell_x, in_cell_y, in_cell_z, in_sublattice);
      end
    end
  end

  initial begin
    int sz;
    int eff;
    int r;
    int place_pct;
    logic [COORD_W-1:0] hx, hy, hz;
    logic [COORD_W-1:0] cx, cy, cz;

    // directed: full size, lattice corners, remove on empty sites
    cur_idle = 0;
    push_cfg(6'd32);
    for (int s = 0; s < 4; s++) push_cmd(CMD_PLACE, 5'd0, 5'd0, 5'd0, SUB_W'(s));
    for (int s = 0; s < 4; s++) push_cmd(CMD_PLACE, 5'd31, 5'd31, 5'd31, SUB_W'(s));
    push_cmd(CMD_REMOVE, 5'd0, 5'd0, 5'd0, 2'd0);
    push_cmd(CMD_REMOVE, 5'd20, 5'd5, 5'd9, 2'd3);
    push_drain();
    // size zero clamps to one: repeated hits saturate at the top
    push_cfg(6'd0);
    for (int i = 0; i < 5; i++) push_cmd(CMD_PLACE, 5'd7, 5'd3, 5'd31, 2'd0);
    push_cmd(CMD_REMOVE, 5'd0, 5'd0, 5'd0, 2'd1);
    push_cfg(6'd2);
    push_cmd(CMD_PLACE, 5'd1, 5'd0, 5'd1, 2'd2);
    push_cmd(CMD_REMOVE, 5'd31, 5'd31, 5'd0, 2'd3);
    push_cmd(CMD_REMOVE, 5'd31, 5'd31, 5'd0, 2'd3);
    push_cfg(6'd63);
    push_cmd(CMD_PLACE, 5'd31, 5'd0, 5'd31, 2'd1);
    push_cmd(CMD_REMOVE, 5'd31, 5'd0, 5'd31, 2'd2);
    push_cfg(6'd3);
    push_cmd(CMD_PLACE, 5'd2, 5'd2, 5'd2, 2'd3);
    push_cmd(CMD_PLACE, 5'd5, 5'd1, 5'd0, 2'd1);
    push_drain();

    // random phases: sender idles 18, then 54, then 0 percent
    for (int ph = 0; ph < 3; ph++) begin
      cur_idle = (ph == 0) ? 18 : (ph == 1) ? 54 : 0;
      for (int k = 0; k < 150; k++) begin
        if (k % 50 == 0) begin
          r = $urandom_range(9);
          if (r < 2) sz = 32;
          else if (r == 2) sz = 3;
          else if (r == 3) sz = $urandom_range(33, 63);
          else if (r == 4) sz = $urandom_range(0, 2);
          else if (r < 8) sz = $urandom_range(3, 8);
          else sz = $urandom_range(9, 32);
          push_cfg(CFG_W'(sz));
          eff = clamp_size(CFG_W'(sz));
          hx = COORD_W'($urandom_range(eff - 1));
          hy = COORD_W'($urandom_range(eff - 1));
          hz = COORD_W'($urandom_range(eff - 1));
        end
        if ($urandom_range(99) < 2) push_drain();
        place_pct = (k % 50 < 30) ? 75 : 35;
        r = $urandom_range(9);
        if (r == 0) begin
          cx = COORD_W'($urandom);
          cy = COORD_W'($urandom);
          cz = COORD_W'($urandom);
        end else if (r < 5) begin
          cx = COORD_W'($urandom_range(eff - 1));
          cy = COORD_W'($urandom_range(eff - 1));
          cz = COORD_W'($urandom_range(eff - 1));
        end else begin
          cx = COORD_W'((int'(hx) + $urandom_range(2)) % eff);
          cy = COORD_W'((int'(hy) + $urandom_range(2)) % eff);
          cz = COORD_W'((int'(hz) + $urandom_range(2)) % eff);
        end
        push_cmd(($urandom_range(99) < place_pct) ? CMD_PLACE : CMD_REMOVE,
                 cx, cy, cz, SUB_W'($urandom_range(3)));
      end
    end

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || nbr_expect_q.size() != 0 || start) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d commands, %0d neighbor words, %0d lattice size writes",
             cmds_taken, words_checked, cfg_writes);
    $display("sizes from clamped zero to clamped 63, %0d saturated updates, idle mixes 18/54/0",
             sat_hits);
    if (errors == 0) begin
      $display("tb_fcc_neighbor_density_update OK");
    end else begin
      $display("tb_fcc_neighbor_density_update NOT OK");
    end
    $finish;
  end

endmodule
